// ===== hw/rtl/lbvc_pkg.sv =====
// Shared types and constants of the load-based voice count governor.
`default_nettype none

package lbvc_pkg;

  // Field and datapath widths
  localparam int unsigned LOAD_W     = 7;   // saturated load, percent
  localparam int unsigned USAGE_W    = 8;   // raw measured load
  localparam int unsigned CNT_W      = 11;  // voice counts
  localparam int unsigned HIST_LEN   = 64;  // entries per history row
  localparam int unsigned HIST_IDX_W = $clog2(HIST_LEN);
  localparam int unsigned SUM_W      = LOAD_W + HIST_IDX_W;
  localparam int unsigned PROD_W     = LOAD_W + CNT_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W);
  localparam int unsigned SUM_CNT_W  = HIST_IDX_W + 1;

  // Streaming and register port widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // Defaults and limits
  localparam int unsigned DEF_HISTORY_ROWS = 92;
  localparam logic [LOAD_W-1:0] DEFAULT_LIMIT = LOAD_W'(70);
  localparam logic [LOAD_W-1:0] LOAD_MAX      = LOAD_W'(127);
  localparam logic [CNT_W-1:0]  INIT_COUNT    = CNT_W'(32);
  localparam logic [CNT_W:0]    COUNT_MIN     = (CNT_W+1)'(4);
  localparam logic [CNT_W-1:0]  RESCALE_MIN   = CNT_W'(3);

  // Register indexes
  localparam logic REG_MAX_USAGE  = 1'b0;
  localparam logic REG_INIT_COUNT = 1'b1;

  // History memory request from the sequencer
  typedef struct packed {
    logic                  rd_en;
    logic [HIST_IDX_W-1:0] rd_idx;
    logic                  wr_en;
    logic [HIST_IDX_W-1:0] wr_idx;
    logic [LOAD_W-1:0]     wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/load_based_voice_count_governor_core.sv =====
// Top level of the load-based voice count governor: sequencer, registers, ports.
// Each input: shift the current history row one entry back and push the load,
//   step the count, sum the physical count's row through the single history
//   memory and, when the row mean exceeds the limit, rescale with the divider.
// Flow: a new input is taken once the previous result is in the output register.
// Reset: asynchronous, active low; history rows read as zero until written,
//   so no clearing pass is needed and input is taken right after reset.
`default_nettype none

module load_based_voice_count_governor_core #(
  parameter int unsigned HISTORY_ROWS = lbvc_pkg::DEF_HISTORY_ROWS
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // tdata: usage_percent [7:0], active_voices [18:8], zero [23:19]
  input  wire logic [lbvc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Output stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // tdata: voice_budget [10:0], physical_voices [21:11], load_cut [22], zero [23]
  output logic      [lbvc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // Register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [lbvc_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [lbvc_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [lbvc_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  localparam int unsigned ROW_W = $clog2(HISTORY_ROWS);
  localparam int unsigned LW    = lbvc_pkg::LOAD_W;
  localparam int unsigned CW    = lbvc_pkg::CNT_W;
  localparam int unsigned IW    = lbvc_pkg::HIST_IDX_W;
  localparam logic [CW-1:0] LAST_ROW = CW'(HISTORY_ROWS - 1);
  localparam logic [lbvc_pkg::SUM_CNT_W-1:0] SUM_END =
    lbvc_pkg::SUM_CNT_W'(lbvc_pkg::HIST_LEN);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT,
    ST_PUSH,
    ST_STEP,
    ST_SUM,
    ST_MEAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  state_e                          state_q, state_d;
  logic [LW-1:0]                   load_q, load_d;
  logic [CW-1:0]                   active_q, active_d;
  logic [ROW_W-1:0]                row_q, row_d;
  logic [lbvc_pkg::SUM_CNT_W-1:0]  k_q, k_d;
  logic [lbvc_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [CW-1:0]                   vc_q, vc_d;
  logic [CW-1:0]                   phys_q, phys_d;
  logic [lbvc_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic                            cut_q, cut_d;
  logic                            out_vld_q, out_vld_d;
  logic [CW-1:0]                   out_budget_q, out_budget_d;
  logic [CW-1:0]                   out_phys_q, out_phys_d;
  logic                            out_cut_q, out_cut_d;
  logic [LW-1:0]                   max_usage_q;
  logic [CW-1:0]                   init_count_q;

  logic [LW-1:0]                   limit;
  logic [LW-1:0]                   mean;
  logic [lbvc_pkg::USAGE_W-1:0]    usage_in;
  logic [CW:0]                     cnt_step;
  logic [CW-1:0]                   cnt_new;
  logic [CW-1:0]                   scaled;
  logic                            cfg_wr;
  lbvc_pkg::mem_req_t              mem_req;
  logic [LW-1:0]                   mem_rd_data;
  logic                            div_start;
  logic                            div_busy;
  logic                            div_done;
  logic [lbvc_pkg::PROD_W-1:0]     div_quo;

  // Pick the history row of a count, capped at the last row
  function automatic logic [ROW_W-1:0] row_of(input logic [CW-1:0] n);
    logic [CW-1:0] r;
    r = (n > LAST_ROW) ? LAST_ROW : n;
    return r[ROW_W-1:0];
  endfunction

  function automatic logic [CW-1:0] min_cnt(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Register port: writes land in the access phase, reads return the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_usage_q  <= '0;
      init_count_q <= lbvc_pkg::INIT_COUNT;
    end else if (cfg_wr) begin
      case (paddr[2])
        lbvc_pkg::REG_MAX_USAGE:  max_usage_q  <= pwdata[LW-1:0];
        lbvc_pkg::REG_INIT_COUNT: init_count_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lbvc_pkg::REG_MAX_USAGE:  prdata = lbvc_pkg::APB_DATA_W'(max_usage_q);
      lbvc_pkg::REG_INIT_COUNT: prdata = lbvc_pkg::APB_DATA_W'(init_count_q);
      default:                  prdata = '0;
    endcase
  end

  // Effective load limit and row mean
  assign limit    = (max_usage_q != '0) ? max_usage_q : lbvc_pkg::DEFAULT_LIMIT;
  assign mean     = sum_q[lbvc_pkg::SUM_W-1:IW];
  assign usage_in = s_axis_tdata[lbvc_pkg::USAGE_W-1:0];

  // Step the governed count by one against the limit (down from zero: to the initial count), then clamp
  always_comb begin
    if (load_q < limit) begin
      cnt_step = {1'b0, vc_q} + 1'b1;
    end else if (load_q > limit) begin
      cnt_step = (vc_q == '0) ? {1'b0, init_count_q} : {1'b0, vc_q} - 1'b1;
    end else begin
      cnt_step = {1'b0, vc_q};
    end
    if (cnt_step < lbvc_pkg::COUNT_MIN) begin
      cnt_step = lbvc_pkg::COUNT_MIN;
    end
    if (cnt_step > {1'b0, init_count_q}) begin
      cnt_step = {1'b0, init_count_q};
    end
    cnt_new = cnt_step[CW-1:0];
  end

  // Rescaled count, at least the rescale floor
  assign scaled = (div_quo[CW-1:0] < lbvc_pkg::RESCALE_MIN) ?
                  lbvc_pkg::RESCALE_MIN : div_quo[CW-1:0];

  // Sequencer
  always_comb begin
    state_d      = state_q;
    load_d       = load_q;
    active_d     = active_q;
    row_d        = row_q;
    k_d          = k_q;
    sum_d        = sum_q;
    vc_d         = vc_q;
    phys_d       = phys_q;
    prod_d       = prod_q;
    cut_d        = cut_q;
    out_vld_d    = out_vld_q;
    out_budget_d = out_budget_q;
    out_phys_d   = out_phys_q;
    out_cut_d    = out_cut_q;
    mem_req      = '0;
    div_start    = 1'b0;

    // Drop the result once the sink takes it
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (usage_in == '0) begin
            load_d = LW'(1);
          end else if (usage_in > lbvc_pkg::USAGE_W'(lbvc_pkg::LOAD_MAX)) begin
            load_d = lbvc_pkg::LOAD_MAX;
          end else begin
            load_d = usage_in[LW-1:0];
          end
          active_d = s_axis_tdata[lbvc_pkg::USAGE_W +: CW];
          row_d    = row_of(vc_q);
          state_d  = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        // Read the second-to-last entry; the last one falls off the row
        mem_req.rd_en  = 1'b1;
        mem_req.rd_idx = IW'(lbvc_pkg::HIST_LEN - 2);
        k_d            = lbvc_pkg::SUM_CNT_W'(lbvc_pkg::HIST_LEN - 1);
        state_d        = ST_SHIFT;
      end
      ST_SHIFT: begin
        // Move each entry one place back, reading two ahead of the write
        mem_req.wr_en   = 1'b1;
        mem_req.wr_idx  = k_q[IW-1:0];
        mem_req.wr_data = mem_rd_data;
        if (k_q > lbvc_pkg::SUM_CNT_W'(1)) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = IW'(k_q - lbvc_pkg::SUM_CNT_W'(2));
        end else begin
          state_d = ST_PUSH;
        end
        k_d = k_q - 1'b1;
      end
      ST_PUSH: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_idx  = '0;
        mem_req.wr_data = load_q;
        state_d         = ST_STEP;
      end
      ST_STEP: begin
        vc_d    = cnt_new;
        phys_d  = min_cnt(cnt_new, active_q);
        row_d   = row_of(min_cnt(cnt_new, active_q));
        k_d     = '0;
        sum_d   = '0;
        cut_d   = 1'b0;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        // Sum the physical count's row, one entry per cycle
        if (k_q != SUM_END) begin
          mem_req.rd_en  = 1'b1;
          mem_req.rd_idx = k_q[IW-1:0];
        end else begin
          state_d = ST_MEAN;
        end
        if (k_q != '0) begin
          sum_d = sum_q + lbvc_pkg::SUM_W'(mem_rd_data);
        end
        k_d = k_q + 1'b1;
      end
      ST_MEAN: begin
        if (mean > limit) begin
          prod_d  = lbvc_pkg::PROD_W'(limit) * lbvc_pkg::PROD_W'(phys_q);
          state_d = ST_DIV_GO;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          vc_d    = scaled;
          phys_d  = min_cnt(scaled, active_q);
          cut_d   = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_budget_d = vc_q;
          out_phys_d   = phys_q;
          out_cut_d    = cut_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      vc_q      <= lbvc_pkg::INIT_COUNT;
      out_vld_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      vc_q      <= vc_d;
      out_vld_q <= out_vld_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    load_q       <= load_d;
    active_q     <= active_d;
    row_q        <= row_d;
    sum_q        <= sum_d;
    phys_q       <= phys_d;
    prod_q       <= prod_d;
    cut_q        <= cut_d;
    out_budget_q <= out_budget_d;
    out_phys_q   <= out_phys_d;
    out_cut_q    <= out_cut_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_cut_q, out_phys_q, out_budget_q};

  lbvc_hist_mem #(
    .HISTORY_ROWS(HISTORY_ROWS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .row_i     (row_q),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  lbvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (mean),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

`ifndef SYNTH
  // A rescaled result never drops below the rescale floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2*CW]) |->
      (m_axis_tdata[CW-1:0] >= lbvc_pkg::RESCALE_MIN))
    else $error("rescaled budget below floor");

  // Physical voices never exceed the budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2*CW-1:CW] <= m_axis_tdata[CW-1:0]))
    else $error("physical voices above budget");

  // The divider runs only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV_WAIT))
    else $error("divider busy outside its wait state");

  // An accepted transaction keeps the input closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened during a step");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lbvc_hist_mem.sv =====
// Load history memory: one row per voice count, counts past the last row sharing it; row valid bits for reset.
`default_nettype none

module lbvc_hist_mem #(
  parameter int unsigned HISTORY_ROWS = lbvc_pkg::DEF_HISTORY_ROWS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [$clog2(HISTORY_ROWS)-1:0]   row_i,
  input  wire lbvc_pkg::mem_req_t                req_i,
  output logic      [lbvc_pkg::LOAD_W-1:0]       rd_data_o
);

  localparam int unsigned ROW_W  = $clog2(HISTORY_ROWS);
  localparam int unsigned DEPTH  = HISTORY_ROWS * lbvc_pkg::HIST_LEN;
  localparam int unsigned ADDR_W = ROW_W + lbvc_pkg::HIST_IDX_W;

  logic [lbvc_pkg::LOAD_W-1:0] mem [DEPTH];
  logic [HISTORY_ROWS-1:0]     row_valid_q;
  logic [lbvc_pkg::LOAD_W-1:0] rd_raw_q;
  logic                        rd_ok_q;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ADDR_W-1:0]           wr_addr;

  assign rd_addr = {row_i, req_i.rd_idx};
  assign wr_addr = {row_i, req_i.wr_idx};

  // Store and read the array
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem[rd_addr];
    end
  end

  // Track which rows hold written data; a full row walk ends at entry zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      if (req_i.wr_en && (req_i.wr_idx == '0)) begin
        row_valid_q[row_i] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_ok_q <= row_valid_q[row_i];
      end
    end
  end

  // Rows never written read as zero
  assign rd_data_o = rd_ok_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/lbvc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module lbvc_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [lbvc_pkg::PROD_W-1:0]   dividend_i,
  input  wire logic [lbvc_pkg::LOAD_W-1:0]   divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic      [lbvc_pkg::PROD_W-1:0]   quotient_o
);

  localparam int unsigned PW = lbvc_pkg::PROD_W;
  localparam int unsigned DW = lbvc_pkg::LOAD_W;
  localparam logic [lbvc_pkg::DIV_CNT_W-1:0] LAST = lbvc_pkg::DIV_CNT_W'(PW - 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [lbvc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]                  rem_q, rem_d;
  logic [DW-1:0]                  dvs_q, dvs_d;
  logic [PW-1:0]                  dq_q, dq_d;
  logic [DW:0]                    trial;
  logic                           fits;

  // Shift in the next dividend bit and try a subtraction
  assign trial = {rem_q, dq_q[PW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dq_d   = dq_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      dq_d   = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
      dq_d  = {dq_q[PW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_load_based_voice_count_governor_core.sv =====
// Self-checking testbench of the load-based voice count governor core.
module tb_load_based_voice_count_governor_core;
  import lbvc_pkg::*;

  localparam int unsigned HISTORY_ROWS   = DEF_HISTORY_ROWS;
  localparam int unsigned LAST_ROW       = HISTORY_ROWS - 1;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES    = 500;

  typedef enum int unsigned {
    PHASE_CLIMB,
    PHASE_OVERLOAD,
    PHASE_HOVER,
    PHASE_NOISE
  } phase_kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] budget;
    logic [CNT_W-1:0] phys;
    logic             cut;
  } budget_t;

  // DUT ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: usage_percent [7:0], active_voices [18:8], zero [23:19]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: voice_budget [10:0], physical_voices [21:11], load_cut [22], zero [23]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Governor state mirror
  logic [LOAD_W-1:0] load_hist [HISTORY_ROWS][HIST_LEN];
  logic [CNT_W-1:0]  gov_count;
  logic [LOAD_W-1:0] cfg_limit;
  logic [CNT_W-1:0]  cfg_init;

  budget_t     pending_budgets[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold = 0;
  bit          burst_mode = 1'b0;
  bit          in_held = 1'b0;

  load_based_voice_count_governor_core #(
    .HISTORY_ROWS(HISTORY_ROWS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Clear the mirror to its power-up state
  task automatic reset_governor_model();
    foreach (load_hist[r, k]) load_hist[r][k] = '0;
    gov_count = INIT_COUNT;
    cfg_limit = '0;
    cfg_init  = INIT_COUNT;
  endtask

  // One governor step: push the load, move the count, rescale on a hot history row
  function automatic budget_t governor_step(input logic [USAGE_W-1:0] usage,
                                            input logic [CNT_W-1:0] active);
    logic [LOAD_W-1:0] load;
    int unsigned       limit, row, phys, sum, mean, scaled;
    logic [63:0]       count;
    budget_t           res;
    if (usage == '0) load = LOAD_W'(1);
    else if (usage > LOAD_MAX) load = LOAD_MAX;
    else load = usage[LOAD_W-1:0];

    row = (gov_count > LAST_ROW) ? LAST_ROW : gov_count;
    for (int k = HIST_LEN - 1; k > 0; k--) load_hist[row][k] = load_hist[row][k-1];
    load_hist[row][0] = load;

    limit = (cfg_limit != '0) ? cfg_limit : DEFAULT_LIMIT;
    // a decrement from zero wraps high and lands on the upper clamp
    count = gov_count;
    if (load < limit) count = count + 1;
    if (load > limit) count = count - 1;
    if (count < COUNT_MIN) count = COUNT_MIN;
    if (count > cfg_init) count = cfg_init;
    gov_count = count[CNT_W-1:0];
    phys = (gov_count < active) ? gov_count : active;

    row = (phys > LAST_ROW) ? LAST_ROW : phys;
    sum = 0;
    for (int k = 0; k < HIST_LEN; k++) sum += load_hist[row][k];
    mean = sum / HIST_LEN;

    res.cut = 1'b0;
    if (mean > limit) begin
      scaled = (limit * phys) / mean;
      if (scaled < RESCALE_MIN) scaled = RESCALE_MIN;
      gov_count = CNT_W'(scaled);
      phys = (gov_count < active) ? gov_count : active;
      res.cut = 1'b1;
    end
    res.budget = gov_count;
    res.phys   = CNT_W'(phys);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  // Drop valid if the last transaction left it high
  task automatic release_input();
    if (in_held) begin
      s_axis_tvalid <= 1'b0;
      in_held = 1'b0;
    end
  endtask

  // Offer one load sample and record its expected budget once taken
  task automatic send_load(input logic [USAGE_W-1:0] usage, input logic [CNT_W-1:0] active);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) release_input();
    repeat (gap) @(posedge clk_i);
    s_axis_tdata  <= IN_TDATA_W'({active, usage});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    in_held = 1'b1;
    pending_budgets.push_back(governor_step(usage, active));
  endtask

  task automatic wait_results_drained();
    release_input();
    while (pending_budgets.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (reg_idx == REG_MAX_USAGE) cfg_limit = value[LOAD_W-1:0];
    else cfg_init = value[CNT_W-1:0];
  endtask

  // Reconfigure only once the core has handed back every result
  task automatic set_governor(input int unsigned limit, input int unsigned init);
    wait_results_drained();
    write_reg(REG_MAX_USAGE, limit);
    write_reg(REG_INIT_COUNT, init);
  endtask

  // Reset defaults against field extremes and all load relations to the limit
  task automatic test_field_extremes();
    send_load(8'd0, 11'd0);
    send_load(8'd1, 11'd1);
    send_load(8'd69, 11'd1023);
    send_load(8'd70, 11'd1024);
    send_load(8'd71, 11'd512);
    send_load(8'd127, 11'd1024);
    send_load(8'd128, 11'd7);
    send_load(8'd255, 11'd1024);
    send_load(8'd200, 11'd0);
    send_load(8'd64, 11'd1023);
  endtask

  // Upper bound of zero (count wraps below zero) and an upper bound below four
  task automatic test_small_initial_count();
    set_governor(100, 0);
    send_load(8'd255, 11'd1024);
    send_load(8'd255, 11'd1024);
    send_load(8'd0, 11'd3);
    set_governor(0, 2);
    send_load(8'd10, 11'd1024);
    send_load(8'd255, 11'd1);
    send_load(8'd70, 11'd2);
  endtask

  // A low limit with heavy load fills one row until the mean forces a rescale
  task automatic test_load_cut();
    set_governor(5, 8);
    send_load(8'd127, 11'd1024);
    send_load(8'd200, 11'd8);
    send_load(8'd127, 11'd6);
    send_load(8'd255, 11'd5);
    send_load(8'd127, 11'd4);
    send_load(8'd127, 11'd4);
    send_load(8'd127, 11'd1024);
    send_load(8'd127, 11'd0);
    send_load(8'd127, 11'd3);
  endtask

  // Climb past the last history row, then overload it under a tight limit
  task automatic test_history_row_cap();
    set_governor(100, 1024);
    repeat (100) send_load($urandom_range(1, 90), $urandom_range(92, 1024));
    set_governor(10, 1024);
    repeat (20) send_load($urandom_range(100, 255),
                          ($urandom_range(0, 1) != 0) ? 11'd1024 : 11'($urandom_range(92, 1024)));
  endtask

  // Stall the result side long enough to back up the input, then pause the sender
  task automatic test_output_backpressure();
    set_governor(0, 64);
    burst_mode = 1'b1;
    rx_hold = HOLD_CYCLES;
    repeat (10) send_load($urandom_range(0, 255), $urandom_range(0, 1024));
    burst_mode = 1'b0;
    wait_results_drained();
    repeat (5) send_load($urandom_range(0, 255), $urandom_range(0, 1024));
  endtask

  // Phases of shaped load under random and extreme settings
  task automatic test_random_phases(input int unsigned item_total);
    int unsigned       sent, run_len, limit, init, lim_eff, lo, hi;
    phase_kind_t       kind;
    logic [CNT_W-1:0]  active;
    sent = 0;
    while (sent < item_total) begin
      case ($urandom_range(0, 3))
        0: limit = 0;
        1: limit = 1;
        2: limit = 100;
        default: limit = $urandom_range(2, 99);
      endcase
      case ($urandom_range(0, 5))
        0: init = 0;
        1: init = $urandom_range(1, 3);
        2: init = 4;
        3: init = 1024;
        4: init = $urandom_range(5, 120);
        default: init = $urandom_range(5, 1024);
      endcase
      set_governor(limit, init);
      burst_mode = ($urandom_range(0, 3) == 0);
      kind = phase_kind_t'($urandom_range(0, 3));
      lim_eff = (limit == 0) ? DEFAULT_LIMIT : limit;
      run_len = $urandom_range(15, 45);
      repeat (run_len) begin
        case (kind)
          PHASE_CLIMB: begin
            lo = 0;
            hi = lim_eff - 1;
          end
          PHASE_OVERLOAD: begin
            lo = lim_eff + 1;
            hi = 255;
          end
          PHASE_HOVER: begin
            lo = (lim_eff > 2) ? lim_eff - 2 : 0;
            hi = lim_eff + 2;
          end
          default: begin
            lo = 0;
            hi = 255;
          end
        endcase
        case ($urandom_range(0, 9))
          0: active = 11'd1024;
          1: active = $urandom_range(0, 8);
          default: active = $urandom_range(0, 1024);
        endcase
        send_load($urandom_range(hi, lo), active);
        sent++;
      end
      burst_mode = 1'b0;
    end
  endtask

  // Result side: random stalls per transaction, or a long hold when requested
  initial begin : result_sink
    int unsigned stall;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Compare each result transaction against the oldest expectation
  always @(posedge clk_i) begin : check_results
    budget_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_budgets.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        want = pending_budgets.pop_front();
        if (m_axis_tdata[10:0] != want.budget)
          report_mismatch("voice_budget", m_axis_tdata[10:0], want.budget);
        if (m_axis_tdata[21:11] != want.phys)
          report_mismatch("physical_voices", m_axis_tdata[21:11], want.phys);
        if (m_axis_tdata[22] != want.cut)
          report_mismatch("load_cut", m_axis_tdata[22], want.cut);
      end
      result_count++;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[load_based_voice_count_governor_core] ERROR");
      $finish;
    end
  end

  initial begin
    reset_governor_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_small_initial_count();
    test_load_cut();
    test_history_row_cap();
    test_output_backpressure();
    test_random_phases(300);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[load_based_voice_count_governor_core] OK");
    end else begin
      $display("[load_based_voice_count_governor_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lbvc_pkg.sv
hw/rtl/lbvc_hist_mem.sv
hw/rtl/lbvc_div.sv
hw/rtl/load_based_voice_count_governor_core.sv
tb/sv/tb_load_based_voice_count_governor_core.sv
